>>> rtl/bsrc_pkg.sv
// shared types and constants for the band-limited sample rate converter
// no dependencies; imported by the controller, datapath and top level
package bsrc_pkg;

   // parameter defaults
   localparam int TAPS_PER_WING_DEF = 16;
   localparam int PHASES_DEF        = 256;
   localparam int HISTORY_DEPTH_DEF = 64;
   localparam int SAMPLE_WIDTH_DEF  = 16;
   localparam int COEFF_WIDTH_DEF   = 18;

   // results per pushed sample
   localparam int MAX_OUT = 16;
   localparam int N_W     = 5;

   // register file
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 25;
   localparam int TSTEP_W    = 20;
   localparam int FSTEP_W    = 25;
   localparam int GAIN_W     = 17;
   localparam int CIDX_W     = 12;

   localparam logic [CSR_IDX_W-1:0] REG_TIME_STEP   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FILTER_STEP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COEFF_INTERP = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN        = 2'd3;

   localparam logic [TSTEP_W-1:0] TIME_STEP_RST   = 20'd65536;
   localparam logic [FSTEP_W-1:0] FILTER_STEP_RST = 25'd16777216;
   localparam logic [GAIN_W-1:0]  GAIN_RST        = 17'd65536;

   // transaction function codes
   localparam logic FUNC_PUSH  = 1'b0;
   localparam logic FUNC_TABLE = 1'b1;

   typedef struct packed {
      logic push;
      logic tab_wr;
      logic wing_init;
      logic wing_sel;
      logic tap_addr;
      logic tap_read;
      logic tap_val;
      logic tap_acc;
      logic scale1;
      logic scale2;
      logic emit;
      logic emit_last;
   } cmd_type;

   typedef struct packed {
      logic lag_neg;
      logic pos_end;
      logic tap_last;
      logic out_busy;
   } status_type;

endpackage

>>> rtl/bandlimited_sample_rate_converter_top.sv
// band-limited sample rate converter top; one item in flight, paced by one shared tap mac
// a table write is taken in the idle state; a push stores the sample, then per output each
// wing is started and its filter taps (up to 32 per wing) go through address, read, value
// and accumulate steps, a wing being cut at the table end; then scaling and the hand-off;
// up to 16 outputs per push; reset: synchronous active-high, clears history, time, counters
// and registers to defaults; the filter table is not cleared and is undefined until written
module bandlimited_sample_rate_converter_top import bsrc_pkg::*; #(
   parameter int TAPS_PER_WING = TAPS_PER_WING_DEF,
   parameter int PHASES        = PHASES_DEF,
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
   parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
   parameter int COEFF_WIDTH   = COEFF_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // configuration writes
   input  logic                           csr_wr_en,
   input  logic [CSR_IDX_W-1:0]           csr_index,
   input  logic [CSR_DATA_W-1:0]          csr_wdata,
   // input transactions
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_func,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic [CIDX_W-1:0]              req_coeff_index,
   input  logic signed [COEFF_WIDTH-1:0]  req_coeff_value,
   // result transactions
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out,
   output logic                           rsp_last_of_run
);

   // command and status between controller and datapath
   cmd_type    cmd;
   status_type status;

   // state machine: accepts transactions, walks both wings tap by tap
   bsrc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // history, table, mac, scaling and the output register that decouples the result side
   bsrc_datapath #(
      .TAPS_PER_WING (TAPS_PER_WING),
      .PHASES        (PHASES),
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .SAMPLE_WIDTH  (SAMPLE_WIDTH),
      .COEFF_WIDTH   (COEFF_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_sample      (req_sample),
      .req_coeff_index (req_coeff_index),
      .req_coeff_value (req_coeff_value),
      .cmd             (cmd),
      .status          (status),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_sample_out  (rsp_sample_out),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

>>> rtl/bsrc_datapath.sv
// datapath: registers, sample history, filter table, shared tap mac and output scaling
// depends on bsrc_pkg; driven by bsrc_controller through cmd_type / status_type
module bsrc_datapath import bsrc_pkg::*; #(
   parameter int TAPS_PER_WING = TAPS_PER_WING_DEF,
   parameter int PHASES        = PHASES_DEF,
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
   parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
   parameter int COEFF_WIDTH   = COEFF_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [CSR_IDX_W-1:0]           csr_index,
   input  logic [CSR_DATA_W-1:0]          csr_wdata,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic [CIDX_W-1:0]              req_coeff_index,
   input  logic signed [COEFF_WIDTH-1:0]  req_coeff_value,
   input  cmd_type                        cmd,
   output status_type                     status,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out,
   output logic                           rsp_last_of_run
);

   localparam int TABLE_LEN = PHASES * TAPS_PER_WING;
   localparam int TE_W      = $clog2(TABLE_LEN);
   localparam int WING_CAP  = HISTORY_DEPTH / 2;
   localparam int HA_W      = $clog2(HISTORY_DEPTH);
   localparam int K_W       = $clog2(WING_CAP);
   localparam int POS_W     = (((TE_W + 16) > 25) ? (TE_W + 16) : 25) + 1;
   localparam int VAL_W     = COEFF_WIDTH + 2;
   localparam int DP_W      = COEFF_WIDTH + 18;
   localparam int PRD_W     = VAL_W + SAMPLE_WIDTH;
   localparam int ACC_W     = PRD_W + HA_W + 1;
   localparam int LO_W      = ACC_W / 2;
   localparam int HI_W      = ACC_W - LO_W;
   localparam int SC_W      = ACC_W + 18;
   localparam int Y_W       = SC_W - 32;
   localparam int OFF_W     = 18;
   localparam logic signed [Y_W-1:0] Y_MAX =
      Y_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
   localparam logic signed [Y_W-1:0] Y_MIN = -Y_MAX - Y_W'(1);

   // configuration
   logic [TSTEP_W-1:0] ts_ff;
   logic [FSTEP_W-1:0] fs_ff;
   logic               interp_ff;
   logic [GAIN_W-1:0]  gain_ff;

   // history and time keeping
   logic signed [SAMPLE_WIDTH-1:0] hist_mem [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0]       hist_vld_ff;
   logic [HA_W-1:0]                hptr_ff, hptr_in;
   logic [15:0]                    cnt_ff, newest_ff;
   logic [31:0]                    ot_ff;

   // filter table
   logic signed [COEFF_WIDTH-1:0] tab_mem [TABLE_LEN];
   logic signed [COEFF_WIDTH-1:0] rd0_ff, rd1_ff;

   // tap pipeline
   logic [POS_W-1:0]               pos_ff;
   logic [K_W-1:0]                 k_ff;
   logic [15:0]                    mu_ff;
   logic                           elast_ff;
   logic                           s_ok_ff;
   logic signed [SAMPLE_WIDTH-1:0] hrd_ff;
   logic signed [COEFF_WIDTH-1:0]  base_ff;
   logic signed [SAMPLE_WIDTH-1:0] samp_ff;
   logic signed [DP_W-1:0]         dprod_ff;
   logic signed [PRD_W-1:0]        mprod_ff;
   logic signed [ACC_W-1:0]        acc_ff;
   logic [LO_W+GAIN_W-1:0]         plo_ff;
   logic signed [HI_W+GAIN_W:0]    phi_ff;
   logic signed [SAMPLE_WIDTH-1:0] yhold_ff;

   // output register
   logic                           rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_ff;
   logic                           rsp_last_ff;

   // combinational
   logic [15:0]            lag;
   logic [16:0]            off0;
   logic [OFF_W-1:0]       off;
   logic                   in_rng;
   logic [HA_W:0]          np, os, hidx_w;
   logic [HA_W-1:0]        hidx;
   logic [16:0]            phase;
   logic [41:0]            init_prod;
   logic [TE_W-1:0]        e, e1;
   logic                   e_last;
   logic [31:0]            widx;
   logic signed [COEFF_WIDTH:0] delta;
   logic signed [VAL_W-1:0]     val;
   logic signed [SC_W-1:0]      sc_sum;
   logic signed [Y_W-1:0]       yw;
   logic signed [SAMPLE_WIDTH-1:0] ysat;

   always_comb begin
      lag    = newest_ff - 16'(WING_CAP) - ot_ff[31:16];
      off0   = {1'b0, lag} + 17'(WING_CAP);
      off    = cmd.wing_sel ? (OFF_W'(off0) - OFF_W'(1) - OFF_W'(k_ff))
                            : (OFF_W'(off0) + OFF_W'(k_ff));
      in_rng = off < OFF_W'(HISTORY_DEPTH);
      np     = {1'b0, hptr_ff};
      os     = {1'b0, off[HA_W-1:0]};
      hidx_w = (np >= os) ? (np - os) : (np + (HA_W+1)'(HISTORY_DEPTH) - os);
      hidx   = hidx_w[HA_W-1:0];
      hptr_in = (hptr_ff == HA_W'(HISTORY_DEPTH - 1)) ? '0 : hptr_ff + HA_W'(1);

      phase     = cmd.wing_sel ? (17'h10000 - {1'b0, ot_ff[15:0]}) : {1'b0, ot_ff[15:0]};
      init_prod = 42'(phase) * 42'(fs_ff);

      e      = pos_ff[TE_W+15:16];
      e_last = e == TE_W'(TABLE_LEN - 1);
      e1     = e_last ? e : e + TE_W'(1);
      widx   = 32'(req_coeff_index);

      delta = elast_ff ? (COEFF_WIDTH+1)'(rd0_ff)
                       : (COEFF_WIDTH+1)'(rd1_ff) - (COEFF_WIDTH+1)'(rd0_ff);
      val   = VAL_W'(base_ff) + (interp_ff ? VAL_W'(dprod_ff >>> 16) : VAL_W'(0));

      sc_sum = (SC_W'(phi_ff) <<< LO_W) + SC_W'($signed({1'b0, plo_ff}))
             + $signed({{(SC_W-32){1'b0}}, 1'b1, 31'b0});
      yw     = sc_sum[SC_W-1:32];
      if (yw > Y_MAX)      ysat = SAMPLE_WIDTH'(Y_MAX);
      else if (yw < Y_MIN) ysat = SAMPLE_WIDTH'(Y_MIN);
      else                 ysat = SAMPLE_WIDTH'(yw);

      status.lag_neg  = lag[15];
      status.pos_end  = pos_ff[POS_W-1:16] >= (POS_W-16)'(TABLE_LEN);
      status.tap_last = k_ff == K_W'(WING_CAP - 1);
      status.out_busy = rsp_valid_ff & rsp_stall;
   end

   // configuration and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ts_ff        <= TIME_STEP_RST;
         fs_ff        <= FILTER_STEP_RST;
         interp_ff    <= 1'b1;
         gain_ff      <= GAIN_RST;
         hist_vld_ff  <= '0;
         hptr_ff      <= '0;
         cnt_ff       <= '0;
         newest_ff    <= '0;
         ot_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               REG_TIME_STEP:    ts_ff     <= csr_wdata[TSTEP_W-1:0];
               REG_FILTER_STEP:  fs_ff     <= csr_wdata[FSTEP_W-1:0];
               REG_COEFF_INTERP: interp_ff <= csr_wdata[0];
               REG_GAIN:         gain_ff   <= csr_wdata[GAIN_W-1:0];
               default: ;
            endcase
         end
         if (cmd.push) begin
            hist_vld_ff[hptr_in] <= 1'b1;
            hptr_ff              <= hptr_in;
            newest_ff            <= cnt_ff;
            cnt_ff               <= cnt_ff + 16'd1;
         end
         if (cmd.scale2) begin
            ot_ff <= ot_ff + 32'(ts_ff);
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // history memory
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         hist_mem[hptr_in] <= req_sample;
      end
      if (cmd.tap_addr) begin
         hrd_ff  <= hist_mem[hidx];
         s_ok_ff <= in_rng & hist_vld_ff[hidx];
      end
   end

   // filter table memory, two read ports
   always_ff @(posedge clock) begin
      if (cmd.tab_wr && (widx < 32'(TABLE_LEN))) begin
         tab_mem[widx[TE_W-1:0]] <= req_coeff_value;
      end
      if (cmd.tap_addr) begin
         rd0_ff <= tab_mem[e];
         rd1_ff <= tab_mem[e1];
      end
   end

   // tap mac and scaling
   always_ff @(posedge clock) begin
      if (cmd.wing_init) begin
         pos_ff <= POS_W'(init_prod >> 16);
         k_ff   <= '0;
         if (!cmd.wing_sel) begin
            acc_ff <= '0;
         end
      end
      if (cmd.tap_addr) begin
         mu_ff    <= pos_ff[15:0];
         elast_ff <= e_last;
      end
      if (cmd.tap_read) begin
         base_ff  <= rd0_ff;
         samp_ff  <= s_ok_ff ? hrd_ff : '0;
         dprod_ff <= DP_W'(delta) * $signed({{(DP_W-17){1'b0}}, 1'b0, mu_ff});
      end
      if (cmd.tap_val) begin
         mprod_ff <= PRD_W'(val) * PRD_W'(samp_ff);
      end
      if (cmd.tap_acc) begin
         acc_ff <= acc_ff + ACC_W'(mprod_ff);
         pos_ff <= pos_ff + POS_W'(fs_ff);
         k_ff   <= k_ff + K_W'(1);
      end
      if (cmd.scale1) begin
         plo_ff <= (LO_W+GAIN_W)'(acc_ff[LO_W-1:0]) * (LO_W+GAIN_W)'(gain_ff);
         phi_ff <= (HI_W+GAIN_W+1)'($signed(acc_ff[ACC_W-1:LO_W]))
                 * $signed({{HI_W{1'b0}}, 1'b0, gain_ff});
      end
      if (cmd.scale2) begin
         yhold_ff <= ysat;
      end
      if (cmd.emit) begin
         rsp_sample_ff <= yhold_ff;
         rsp_last_ff   <= cmd.emit_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_out  = rsp_sample_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

>>> rtl/bsrc_controller.sv
// controller: sequences pushes, wings, taps, scaling and result hand-off
// depends on bsrc_pkg; commands bsrc_datapath through cmd_type / status_type
module bsrc_controller import bsrc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_func,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_CHECK  = 9'b000000010,
      S_WINIT  = 9'b000000100,
      S_TADDR  = 9'b000001000,
      S_TREAD  = 9'b000010000,
      S_TVAL   = 9'b000100000,
      S_TACC   = 9'b001000000,
      S_SCALE1 = 9'b010000000,
      S_SCALE2 = 9'b100000000
   } state_type;

   state_type      state_ff, state_in;
   logic [N_W-1:0] n_ff, n_in;
   logic           pend_ff, pend_in;
   logic           wsel_ff, wsel_in;
   logic           stop;

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      pend_in  = pend_ff;
      wsel_in  = wsel_ff;
      cmd      = '0;
      cmd.wing_sel = wsel_ff;
      stop     = status.lag_neg | (n_ff == N_W'(MAX_OUT));
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_func == FUNC_TABLE) begin
                  cmd.tab_wr = 1'b1;
               end else begin
                  cmd.push = 1'b1;
                  n_in     = '0;
                  pend_in  = 1'b0;
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (!(pend_ff && status.out_busy)) begin
               if (pend_ff) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_last = stop;
                  pend_in       = 1'b0;
               end
               if (stop) begin
                  state_in = S_IDLE;
               end else begin
                  wsel_in  = 1'b0;
                  state_in = S_WINIT;
               end
            end
         end
         S_WINIT: begin
            cmd.wing_init = 1'b1;
            state_in      = S_TADDR;
         end
         S_TADDR: begin
            if (status.pos_end) begin
               if (!wsel_ff) begin
                  wsel_in  = 1'b1;
                  state_in = S_WINIT;
               end else begin
                  state_in = S_SCALE1;
               end
            end else begin
               cmd.tap_addr = 1'b1;
               state_in     = S_TREAD;
            end
         end
         S_TREAD: begin
            cmd.tap_read = 1'b1;
            state_in     = S_TVAL;
         end
         S_TVAL: begin
            cmd.tap_val = 1'b1;
            state_in    = S_TACC;
         end
         S_TACC: begin
            cmd.tap_acc = 1'b1;
            if (!status.tap_last) begin
               state_in = S_TADDR;
            end else if (!wsel_ff) begin
               wsel_in  = 1'b1;
               state_in = S_WINIT;
            end else begin
               state_in = S_SCALE1;
            end
         end
         S_SCALE1: begin
            cmd.scale1 = 1'b1;
            state_in   = S_SCALE2;
         end
         S_SCALE2: begin
            cmd.scale2 = 1'b1;
            n_in       = n_ff + N_W'(1);
            pend_in    = 1'b1;
            state_in   = S_CHECK;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         n_ff     <= '0;
         pend_ff  <= 1'b0;
         wsel_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
         pend_ff  <= pend_in;
         wsel_ff  <= wsel_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;

`ifndef SYNTH
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !status.out_busy)
      else $error("result loaded while output register held");
   a_n_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= N_W'(MAX_OUT))
      else $error("result count beyond limit");
   a_scale_check: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCALE2 |=> state_ff == S_CHECK && pend_ff)
      else $error("scaled result not handed to check");
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && stop && !(pend_ff && status.out_busy))
      |=> state_ff == S_IDLE && !pend_ff)
      else $error("run ended with result pending");
`endif

endmodule

>>> sim/tb_bandlimited_sample_rate_converter_top.sv
// self-checking testbench for the band-limited sample rate converter top level
// depends on bsrc_pkg and bandlimited_sample_rate_converter_top; holds its own resampler model
`timescale 1ns / 1ps

module tb_bandlimited_sample_rate_converter_top;
   import bsrc_pkg::*;

   localparam int TABLE_LEN = PHASES_DEF * TAPS_PER_WING_DEF;
   localparam int HIST_LEN  = HISTORY_DEPTH_DEF;
   localparam int WING_TAPS = HISTORY_DEPTH_DEF / 2;
   localparam int SETTLE    = 400;   // cycles after the last result before touching registers

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_func;
   logic signed [15:0]     req_sample;
   logic [CIDX_W-1:0]      req_coeff_index;
   logic signed [17:0]     req_coeff_value;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic signed [15:0]     rsp_sample_out;
   logic                   rsp_last_of_run;

   bandlimited_sample_rate_converter_top dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_sample(req_sample), .req_coeff_index(req_coeff_index),
      .req_coeff_value(req_coeff_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_sample_out(rsp_sample_out), .rsp_last_of_run(rsp_last_of_run)
   );

   // one expected output sample
   typedef struct {
      logic signed [15:0] sample_out;
      logic               last;
   } resampled_t;

   // one row of the directed stimulus; typed_count < 0 leaves it to the model
   typedef struct {
      logic               func;
      logic signed [15:0] sample;
      logic [11:0]        index;
      logic signed [17:0] value;
      int                 typed_count;
   } directed_row_t;

   resampled_t  resampled_q[$];
   int          err_count;
   int          push_count_tb;
   int          table_wr_count;
   int          checked_count;
   int          idle_send_pct;
   int          idle_rcv_pct;

   // resampler state, kept next to the block
   logic signed [15:0] hist_mem[HIST_LEN];
   logic signed [17:0] coef_mem[TABLE_LEN];
   int unsigned        hist_head;
   int unsigned        out_time;
   logic [15:0]        sample_count;
   int unsigned        cfg_tstep;
   int unsigned        cfg_fstep;
   int unsigned        cfg_interp;
   int unsigned        cfg_gain;

   // directed part: extremes of every field, last table entry, warm-up with no output
   directed_row_t dir_rows[15] = '{
      '{FUNC_TABLE, 16'sd0,      12'd0,    18'sd131071, 0},
      '{FUNC_TABLE, 16'sd0,      12'd4095, -18'sd131072, 0},
      '{FUNC_TABLE, 16'sd0,      12'd1,    18'sd0,      0},
      '{FUNC_TABLE, 16'sd0,      12'd2048, -18'sd1,     0},
      '{FUNC_TABLE, 16'sd0,      12'd2049, 18'sd1,      0},
      '{FUNC_PUSH,  16'sd32767,  12'd0,    18'sd0,      0},
      '{FUNC_PUSH,  -16'sd32768, 12'd0,    18'sd0,      0},
      '{FUNC_PUSH,  16'sd0,      12'd0,    18'sd0,      0},
      '{FUNC_PUSH,  -16'sd1,     12'd0,    18'sd0,      0},
      '{FUNC_PUSH,  16'sd1,      12'd0,    18'sd0,      0},
      '{FUNC_PUSH,  16'sd32767,  12'd4095, -18'sd1,     0},
      '{FUNC_PUSH,  -16'sd32768, 12'd4095, -18'sd1,     0},
      '{FUNC_PUSH,  16'sd21845,  12'd0,    18'sd0,      0},
      '{FUNC_PUSH,  -16'sd21846, 12'd0,    18'sd0,      0},
      '{FUNC_PUSH,  16'sd12345,  12'd0,    18'sd0,      0}
   };

   // clock generation
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard limit on run time
   initial begin
      #50_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      err_count++;
   endtask

   // filter value at Q16 table position, optionally interpolated
   function automatic longint coef_at(input longint unsigned pos);
      int unsigned e;
      longint      b;
      longint      d;
      e = int'(pos >> 16);
      b = coef_mem[e];
      if (cfg_interp == 0) return b;
      // the last entry uses itself as delta
      d = (e + 1 < TABLE_LEN) ? longint'(coef_mem[e + 1]) - b : b;
      return b + ((d * longint'(pos & 64'hFFFF)) >>> 16);
   endfunction

   // one wing of the convolution; off0 is the age of the sample at the output time
   function automatic longint wing_sum(input int unsigned phase, input int unsigned off0,
                                      input bit right);
      longint unsigned pos;
      longint          acc;
      int unsigned     off;
      longint          s;
      pos = (64'(phase) * 64'(cfg_fstep)) >> 16;
      acc = 0;
      for (int k = 0; k < WING_TAPS; k++) begin
         if ((pos >> 16) >= TABLE_LEN) break;
         off = right ? off0 - 1 - k : off0 + k;
         s = 0;
         // samples gone from the history read as zero
         if (off < HIST_LEN) s = hist_mem[(hist_head + HIST_LEN - off) % HIST_LEN];
         acc += coef_at(pos) * s;
         pos += cfg_fstep;
      end
      return acc;
   endfunction

   // push a sample and queue every output time it completes
   function automatic int resample_push(input logic signed [15:0] smp);
      int unsigned newest;
      int unsigned base;
      int unsigned frac;
      int unsigned lag;
      int unsigned off0;
      longint      acc;
      longint      y;
      int          n;
      resampled_t  r;
      hist_head = (hist_head + 1) % HIST_LEN;
      hist_mem[hist_head] = smp;
      newest = sample_count;
      sample_count = sample_count + 16'd1;
      n = 0;
      while (n < MAX_OUT) begin
         base = (out_time >> 16) & 32'hFFFF;
         frac = out_time & 32'hFFFF;
         lag  = (newest - WING_TAPS - base) & 32'hFFFF;
         if (lag[15]) break;   // right wing not yet in the history
         off0 = lag + WING_TAPS;
         acc = wing_sum(frac, off0, 1'b0) + wing_sum(65536 - frac, off0, 1'b1);
         y = (acc * longint'(cfg_gain) + (64'sd1 <<< 31)) >>> 32;
         if (y > 32767) y = 32767;
         if (y < -32768) y = -32768;
         r.sample_out = y[15:0];
         r.last = 1'b0;
         resampled_q.push_back(r);
         n++;
         out_time += cfg_tstep;
      end
      if (n > 0) resampled_q[resampled_q.size() - 1].last = 1'b1;
      return n;
   endfunction

   // one input transaction with random idling before it
   task automatic send_item(input logic f, input logic signed [15:0] smp,
                            input logic [11:0] ci, input logic signed [17:0] cv,
                            output int n_out);
      while ($urandom_range(99) < idle_send_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= f;
      req_sample      <= smp;
      req_coeff_index <= ci;
      req_coeff_value <= cv;
      do @(posedge clock); while (req_stall);
      if (f == FUNC_TABLE) begin
         coef_mem[ci] = cv;
         table_wr_count++;
         n_out = 0;
      end else begin
         push_count_tb++;
         n_out = resample_push(smp);
      end
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input int unsigned val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         REG_TIME_STEP:    cfg_tstep  = val & 32'hFFFFF;
         REG_FILTER_STEP:  cfg_fstep  = val & 32'h1FFFFFF;
         REG_COEFF_INTERP: cfg_interp = val & 32'h1;
         REG_GAIN:         cfg_gain   = val & 32'h1FFFF;
         default: ;
      endcase
   endtask

   // wait for every queued result, then let the block go quiet
   task automatic drain;
      req_valid <= 1'b0;
      while (resampled_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic random_items(input int count);
      int n;
      logic signed [15:0] smp;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 10) begin
            // table rewrite, mostly gentle values so sums stay in range
            send_item(FUNC_TABLE, 16'sd0, 12'($urandom),
                      ($urandom_range(99) < 70) ? 18'($urandom_range(4095)) - 18'sd2048
                                                : 18'($urandom), n);
         end else begin
            case ($urandom_range(9))
               0: smp = 16'sh7FFF;
               1: smp = 16'sh8000;
               default: smp = 16'($urandom);
            endcase
            send_item(FUNC_PUSH, smp, 12'($urandom), 18'($urandom), n);
         end
      end
   endtask

   // result side: random stall, in-order field check
   always @(posedge clock) begin
      resampled_t e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (resampled_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result %0d", rsp_sample_out));
         end else begin
            e = resampled_q.pop_front();
            checked_count++;
            if (rsp_sample_out !== e.sample_out)
               report_mismatch($sformatf("sample_out %0d, expected %0d",
                                         rsp_sample_out, e.sample_out));
            if (rsp_last_of_run !== e.last)
               report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                         rsp_last_of_run, e.last));
         end
      end
      rsp_stall <= ($urandom_range(99) < idle_rcv_pct);
   end

   initial begin
      int n;
      // register settings per phase: time step, filter step, interpolation, gain
      int unsigned ph_tstep[5]  = '{4096,  524288,   100000, 50000,    0};
      int unsigned ph_fstep[5]  = '{1,     16777216, 200000, 8388608,  0};
      int unsigned ph_interp[5] = '{0,     1,        1,      0,        0};
      int unsigned ph_gain[5]   = '{65536, 0,        40000,  65535,    0};

      err_count = 0;
      push_count_tb = 0;
      table_wr_count = 0;
      checked_count = 0;
      idle_send_pct = 28;
      idle_rcv_pct  = 86;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_func = FUNC_PUSH;
      req_sample = '0;
      req_coeff_index = '0;
      req_coeff_value = '0;
      rsp_stall = 1'b0;

      // model state after reset
      foreach (hist_mem[i]) hist_mem[i] = '0;
      foreach (coef_mem[i]) coef_mem[i] = '0;
      hist_head = 0;
      out_time = 0;
      sample_count = '0;
      cfg_tstep = TIME_STEP_RST;
      cfg_fstep = FILTER_STEP_RST;
      cfg_interp = 1;
      cfg_gain = GAIN_RST;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // the table powers up undefined: fill every entry before any push reads it
      for (int i = 0; i < TABLE_LEN; i++)
         send_item(FUNC_TABLE, 16'sd0, 12'(i), 18'($urandom_range(4095)) - 18'sd2048, n);

      // directed rows, still in the reset configuration
      foreach (dir_rows[i]) begin
         send_item(dir_rows[i].func, dir_rows[i].sample, dir_rows[i].index,
                   dir_rows[i].value, n);
         if (dir_rows[i].typed_count >= 0 && n != dir_rows[i].typed_count)
            report_mismatch($sformatf("directed row %0d gave %0d outputs", i, n));
      end
      random_items(35);

      // each phase rewrites every register; idling pattern changes before phases 1 and 3
      for (int p = 0; p < 5; p++) begin
         drain();
         if (p == 1) begin
            idle_send_pct = 86;
            idle_rcv_pct  = 28;
         end else if (p == 3) begin
            idle_send_pct = 0;
            idle_rcv_pct  = 0;
         end
         if (p == 4) begin
            csr_write(REG_TIME_STEP,    $urandom_range(524288, 4096));
            csr_write(REG_FILTER_STEP,  $urandom_range(16777216, 1));
            csr_write(REG_COEFF_INTERP, $urandom_range(1));
            csr_write(REG_GAIN,         $urandom_range(65536));
         end else begin
            csr_write(REG_TIME_STEP,    ph_tstep[p]);
            csr_write(REG_FILTER_STEP,  ph_fstep[p]);
            csr_write(REG_COEFF_INTERP, ph_interp[p]);
            csr_write(REG_GAIN,         ph_gain[p]);
         end
         random_items(35);
      end

      drain();
      if (resampled_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", resampled_q.size()));
      $display("covered %0d sample pushes and %0d table writes over six register settings",
               push_count_tb, table_wr_count);
      $display("%0d output samples compared, %0d mismatches", checked_count, err_count);
      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/bsrc_pkg.sv
rtl/bsrc_datapath.sv
rtl/bsrc_controller.sv
rtl/bandlimited_sample_rate_converter_top.sv
sim/tb_bandlimited_sample_rate_converter_top.sv
